FILE: rtl/pivt_pkg.sv
`default_nettype none
package pivt_pkg;

    localparam int X_PIXELS    = 384;
    localparam int Y_PIXELS    = 128;
    localparam int PIXEL_COUNT = X_PIXELS * Y_PIXELS;
    localparam int IDX_W       = $clog2(PIXEL_COUNT);

    localparam int KIND_W   = 2;
    localparam int TIME_W   = 63;
    localparam int X_W      = 9;
    localparam int Y_W      = 7;
    localparam int WINDOW_W = 40;
    localparam int COUNT_W  = 32;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 40'd150000000000;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_GATED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IMPLANT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READOUT = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] event_time;
        logic [X_W-1:0]    pixel_x;
        logic [Y_W-1:0]    pixel_y;
    } t_in_word;

    typedef struct packed {
        logic               vetoed;
        logic               same_time_skip;
        logic               entry_valid;
        logic [TIME_W-1:0]  entry_time;
        logic [COUNT_W-1:0] veto_total;
    } t_out_word;

    typedef struct packed {
        logic             load;
        logic             rd;
        logic             diff;
        logic             exec;
        logic             clr_we;
        logic [IDX_W-1:0] clr_addr;
    } t_cmd;

endpackage
`default_nettype wire

FILE: rtl/pixel_implant_veto_table.sv
// Result word registered in the EXEC state, after the READ and DIFF states;
// EXEC waits while an unaccepted result is held. One word at a time (accept,
// pixel read, time difference, update and write-back), set by the single-port
// pixel table sequencer. Reset: synchronous, active low; a clearing pass then
// runs over all 49152 pixel valid map entries with input ready held low.
`default_nettype none
module pixel_implant_veto_table
    import pivt_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  t_in_word            i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output t_out_word           o_out_word,
    input  wire                 i_cfg_we,
    input  wire  [WINDOW_W-1:0] i_cfg_data
);

    t_cmd w_cmd;

    pivt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    pivt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_out_word (o_out_word)
    );

endmodule
`default_nettype wire

FILE: rtl/pivt_ctrl.sv
`default_nettype none
module pivt_ctrl
    import pivt_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  wire  i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DIFF  = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_clr_addr, n_clr_addr;
    logic             r_out_valid, n_out_valid;
    logic             w_exec;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        w_exec     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == IDX_W'(PIXEL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    w_exec  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || w_exec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.rd       = (r_state == S_READ);
    assign o_cmd.diff     = (r_state == S_DIFF);
    assign o_cmd.exec     = w_exec;
    assign o_cmd.clr_we   = (r_state == S_CLEAR);
    assign o_cmd.clr_addr = r_clr_addr;

endmodule
`default_nettype wire

FILE: rtl/pivt_dp.sv
`default_nettype none
module pivt_dp
    import pivt_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_cmd                i_cmd,
    input  t_in_word            i_in_word,
    input  wire                 i_cfg_we,
    input  wire  [WINDOW_W-1:0] i_cfg_data,
    output t_out_word           o_out_word
);

    logic [TIME_W-1:0] r_time_mem [PIXEL_COUNT];
    logic              r_valid_mem [PIXEL_COUNT];

    t_in_word           r_in;
    t_out_word          r_out, n_out;
    logic [WINDOW_W-1:0] r_window;
    logic [TIME_W-1:0]  r_latest, n_latest;
    logic               r_seen, n_seen;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [TIME_W-1:0]  r_rd_time;
    logic               r_rd_bit;
    logic [TIME_W-1:0]  r_diff;
    logic               r_borrow;
    logic               r_same;

    logic             w_in_range;
    logic [IDX_W-1:0] w_idx;
    logic             w_entry_valid;
    logic             w_below;
    logic             w_time_we;
    logic             w_valid_we;
    logic             w_valid_wbit;
    logic             w_exec_vwe;
    logic             w_exec_vbit;
    logic [IDX_W-1:0] w_valid_addr;

    assign w_in_range = (32'(r_in.pixel_x) < 32'(X_PIXELS))
                     && (32'(r_in.pixel_y) < 32'(Y_PIXELS));
    assign w_idx = IDX_W'(r_in.pixel_y) * IDX_W'(X_PIXELS) + IDX_W'(r_in.pixel_x);
    assign w_entry_valid = w_in_range && r_rd_bit;
    assign w_below = r_borrow || (r_diff < {{(TIME_W-WINDOW_W){1'b0}}, r_window});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_word;
        end
        if (i_cmd.rd) begin
            r_rd_time <= r_time_mem[w_idx];
            r_rd_bit  <= r_valid_mem[w_idx];
        end
        if (i_cmd.diff) begin
            {r_borrow, r_diff} <= {1'b0, r_in.event_time} - {1'b0, r_rd_time};
            r_same <= r_seen && (r_in.event_time == r_latest);
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_out        = '0;
        n_latest     = r_latest;
        n_seen       = r_seen;
        n_count      = r_count;
        w_time_we    = 1'b0;
        w_exec_vwe   = 1'b0;
        w_exec_vbit  = 1'b0;
        unique case (r_in.kind)
            KIND_GATED: begin
                n_latest    = r_in.event_time;
                n_seen      = 1'b1;
                w_time_we   = w_in_range;
                w_exec_vwe  = w_in_range;
                w_exec_vbit = 1'b1;
            end
            KIND_IMPLANT: begin
                if (r_same) begin
                    n_out.same_time_skip = 1'b1;
                end else if (w_entry_valid && w_below) begin
                    n_out.vetoed = 1'b1;
                    w_exec_vwe   = 1'b1;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            KIND_READOUT: begin
                n_out.entry_valid = w_entry_valid;
                n_out.entry_time  = w_entry_valid ? r_rd_time : '0;
            end
            default: begin
            end
        endcase
        n_out.veto_total = n_count;
    end

    assign w_valid_we   = i_cmd.clr_we || (i_cmd.exec && w_exec_vwe);
    assign w_valid_wbit = i_cmd.clr_we ? 1'b0 : w_exec_vbit;
    assign w_valid_addr = i_cmd.clr_we ? i_cmd.clr_addr : w_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_time_we) begin
            r_time_mem[w_idx] <= r_in.event_time;
        end
        if (w_valid_we) begin
            r_valid_mem[w_valid_addr] <= w_valid_wbit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_latest <= '0;
            r_seen   <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_latest <= n_latest;
                r_seen   <= n_seen;
                r_count  <= n_count;
            end
        end
    end

    assign o_out_word = r_out;

endmodule
`default_nettype wire

FILE: test/veto_table_monitor.sv
`timescale 1ns / 1ps
module veto_table_monitor
    import pivt_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_ready,
    input  t_in_word            i_in_word,
    input  wire                 i_out_valid,
    input  wire                 i_out_ready,
    input  t_out_word           i_out_word,
    input  wire                 i_cfg_we,
    input  wire  [WINDOW_W-1:0] i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_compared,
    output int                  o_vetoes,
    output int                  o_skips,
    output int                  o_live_reads
);

    logic [WINDOW_W-1:0] window_ns;
    logic                gate_live [PIXEL_COUNT];
    logic [TIME_W-1:0]   gate_stamp [PIXEL_COUNT];
    logic [TIME_W-1:0]   last_gate_time;
    logic                last_gate_seen;
    logic [COUNT_W-1:0]  veto_count;
    t_out_word           awaited_words [$];
    int                  errs = 0;
    int                  compared = 0;
    int                  vetoes = 0;
    int                  skips = 0;
    int                  live_reads = 0;

    function automatic t_out_word veto_table_step(input t_in_word w);
        t_out_word r;
        logic      on_grid;
        int        idx;
        r = '0;
        on_grid = (int'(w.pixel_x) < X_PIXELS) && (int'(w.pixel_y) < Y_PIXELS);
        idx = int'(w.pixel_y) * X_PIXELS + int'(w.pixel_x);
        case (w.kind)
            KIND_GATED: begin
                last_gate_time = w.event_time;
                last_gate_seen = 1'b1;
                if (on_grid) begin
                    gate_stamp[idx] = w.event_time;
                    gate_live[idx] = 1'b1;
                end
            end
            KIND_IMPLANT: begin
                if (last_gate_seen && w.event_time == last_gate_time) begin
                    r.same_time_skip = 1'b1;
                end else if (on_grid && gate_live[idx]) begin
                    if (w.event_time < gate_stamp[idx] ||
                        (w.event_time - gate_stamp[idx]) < window_ns) begin
                        gate_live[idx] = 1'b0;
                        r.vetoed = 1'b1;
                        if (veto_count != COUNT_MAX) veto_count = veto_count + 1'b1;
                    end
                end
            end
            KIND_READOUT: begin
                if (on_grid && gate_live[idx]) begin
                    r.entry_valid = 1'b1;
                    r.entry_time = gate_stamp[idx];
                end
            end
            default: ;
        endcase
        r.veto_total = veto_count;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            window_ns = WINDOW_RESET;
            for (int i = 0; i < PIXEL_COUNT; i++) gate_live[i] = 1'b0;
            last_gate_time = '0;
            last_gate_seen = 1'b0;
            veto_count = '0;
            awaited_words.delete();
        end else begin
            if (i_cfg_we) window_ns = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (awaited_words.size() == 0) begin
                    $error("result word arrived with no prediction waiting");
                    errs++;
                end else begin
                    want = awaited_words.pop_front();
                    compared++;
                    compare_field("vetoed", want.vetoed, i_out_word.vetoed);
                    compare_field("same_time_skip", want.same_time_skip,
                                  i_out_word.same_time_skip);
                    compare_field("entry_valid", want.entry_valid, i_out_word.entry_valid);
                    compare_field("entry_time", want.entry_time, i_out_word.entry_time);
                    compare_field("veto_total", want.veto_total, i_out_word.veto_total);
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = veto_table_step(i_in_word);
                vetoes += want.vetoed;
                skips += want.same_time_skip;
                live_reads += want.entry_valid;
                awaited_words.push_back(want);
            end
        end
        o_fail_count <= errs;
        o_pending <= awaited_words.size();
        o_compared <= compared;
        o_vetoes <= vetoes;
        o_skips <= skips;
        o_live_reads <= live_reads;
    end

endmodule

FILE: test/tb_pixel_implant_veto_table.sv
`timescale 1ns / 1ps
module tb_pixel_implant_veto_table;
    import pivt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam int X_TOP = (1 << X_W) - 1;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD = 150;
    localparam int WATCHDOG_LIMIT = 200000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    t_in_word            in_word;
    logic                out_valid;
    logic                out_ready;
    t_out_word           out_word;
    logic                cfg_we;
    logic [WINDOW_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int compared;
    int vetoes;
    int skips;
    int live_reads;

    int                  phase_no = -1;
    bit                  quiet = 1'b0;
    bit                  long_hold_done = 1'b0;
    int                  stuck_cycles = 0;
    logic [WINDOW_W-1:0] window_now;
    logic [TIME_W-1:0]   stamp_cursor;
    logic [TIME_W-1:0]   last_gated;
    bit                  gated_mark [PIXEL_COUNT];
    logic [TIME_W-1:0]   gated_stamp [PIXEL_COUNT];
    int                  gated_list [$];

    pixel_implant_veto_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    veto_table_monitor monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared),
        .o_vetoes     (vetoes),
        .o_skips      (skips),
        .o_live_reads (live_reads)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("pixel_implant_veto_table verification failed");
            $finish;
        end
    end

    function automatic logic [TIME_W-1:0] later(input logic [TIME_W-1:0] base,
                                                input logic [63:0] step);
        logic [63:0] s;
        s = {1'b0, base} + step;
        return (s > {1'b0, TIME_MAX}) ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] earlier(input logic [TIME_W-1:0] base,
                                                  input logic [63:0] step);
        return ({1'b0, base} > step) ? base - step[TIME_W-1:0] : '0;
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    function automatic logic [63:0] random_step();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1, 2, 3, 4: return 64'($urandom_range(1, 1000));
            5, 6, 7: return 64'($urandom);
            8: return {24'd0, 8'($urandom_range(0, 255)), $urandom};
            default: return 64'($urandom_range(1, 50)) * 64'd1000000000;
        endcase
    endfunction

    function automatic int recent_target();
        int n;
        n = gated_list.size();
        if (n == 0) return -1;
        if ($urandom_range(0, 3) != 0)
            return gated_list[n - 1 - $urandom_range(0, (n > 16) ? 15 : n - 1)];
        return gated_list[$urandom_range(0, n - 1)];
    endfunction

    task automatic issue(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] t,
                         input int x, input int y);
        t_in_word w;
        int       idx;
        int       gap;
        w.kind = kind;
        w.event_time = t;
        w.pixel_x = x[X_W-1:0];
        w.pixel_y = y[Y_W-1:0];
        if (kind == KIND_GATED) begin
            last_gated = t;
            if (x < X_PIXELS) begin
                idx = y * X_PIXELS + x;
                if (!gated_mark[idx]) gated_list.push_back(idx);
                gated_mark[idx] = 1'b1;
                gated_stamp[idx] = t;
            end
        end
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic random_item();
        int                roll;
        int                p;
        int                x;
        int                y;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] s;
        logic [KIND_W-1:0] kind;
        roll = $urandom_range(0, 99);
        p = recent_target();
        if (p < 0 || $urandom_range(0, 9) == 0) begin
            x = $urandom_range(X_PIXELS, X_TOP);
            y = $urandom_range(0, Y_PIXELS - 1);
        end else begin
            x = p % X_PIXELS;
            y = p / X_PIXELS;
        end
        if ($urandom_range(0, 149) == 0) stamp_cursor = rand_time();
        if (roll < 30) begin
            kind = KIND_GATED;
            if (x < X_PIXELS && $urandom_range(0, 2) != 0) begin
                x = $urandom_range(0, X_PIXELS - 1);
                y = $urandom_range(0, Y_PIXELS - 1);
            end
            stamp_cursor = later(stamp_cursor, random_step());
            t = stamp_cursor;
        end else if (roll < 60) begin
            kind = KIND_IMPLANT;
            s = (x < X_PIXELS) ? gated_stamp[y * X_PIXELS + x] : last_gated;
            case ($urandom_range(0, 7))
                0: t = last_gated;
                1: t = later(s, (window_now == '0) ? 64'd0 : 64'(window_now) - 64'd1);
                2: t = later(s, 64'(window_now));
                3: t = later(s, 64'(window_now) + 64'd1);
                4: t = later(s, 64'($urandom_range(0, 1000)));
                5: t = earlier(s, 64'($urandom_range(1, 1000)));
                default: t = later(stamp_cursor, random_step());
            endcase
            if (t > stamp_cursor) stamp_cursor = t;
        end else if (roll < 85) begin
            kind = KIND_READOUT;
            t = ($urandom_range(0, 4) == 0) ? rand_time() : stamp_cursor;
        end else if (roll < 93) begin
            kind = KIND_IMPLANT;
            t = rand_time();
        end else begin
            kind = KIND_SPARE;
            t = rand_time();
        end
        issue(kind, t, x, y);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [WINDOW_W-1:0] w);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        window_now = w;
    endtask

    initial begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (quiet) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else if (phase_no == 2 && !long_hold_done) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
                if ($urandom_range(0, 1) == 0) begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 7)) @(posedge clk);
                end
            end
        end
    end

    initial begin
        logic [WINDOW_W-1:0] w;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_word <= '0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        window_now = WINDOW_RESET;
        stamp_cursor = '0;
        last_gated = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        issue(KIND_IMPLANT, '0, X_TOP, Y_PIXELS - 1);
        issue(KIND_READOUT, '0, X_PIXELS, 0);
        issue(KIND_SPARE, TIME_MAX, X_TOP, 0);
        issue(KIND_GATED, 63'd100, 0, 0);
        issue(KIND_READOUT, 63'd100, 0, 0);
        issue(KIND_IMPLANT, 63'd100, 0, 0);
        issue(KIND_IMPLANT, 63'd101, 0, 0);
        issue(KIND_READOUT, 63'd101, 0, 0);
        issue(KIND_GATED, 63'd1000, X_PIXELS - 1, Y_PIXELS - 1);
        issue(KIND_IMPLANT, 63'd1000 + 63'(WINDOW_RESET), X_PIXELS - 1, Y_PIXELS - 1);
        issue(KIND_IMPLANT, 63'd999 + 63'(WINDOW_RESET), X_PIXELS - 1, Y_PIXELS - 1);
        issue(KIND_GATED, 63'd500000000000, 200, 64);
        issue(KIND_IMPLANT, 63'd400000000000, 200, 64);
        issue(KIND_GATED, 63'd600000000000, 400, 5);
        issue(KIND_IMPLANT, 63'd600000000000, 400, 5);
        issue(KIND_IMPLANT, 63'd700000000000, 0, 0);
        issue(KIND_GATED, TIME_MAX, 0, 0);
        issue(KIND_READOUT, TIME_MAX, 0, 0);
        issue(KIND_IMPLANT, TIME_MAX, 0, 0);
        issue(KIND_SPARE, '0, 0, 0);
        issue(KIND_READOUT, '0, X_PIXELS - 1, Y_PIXELS - 1);
        issue(KIND_READOUT, '0, 200, 64);
        issue(KIND_GATED, 63'd5, 255, 100);
        issue(KIND_IMPLANT, 63'd6, 255, 100);
        stamp_cursor = 63'd1000;

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: w = '0;
                1: w = '1;
                2: w = 40'd1;
                3: w = {8'($urandom_range(0, 255)), $urandom};
                4: w = WINDOW_RESET;
                default: w = 40'($urandom_range(1, 1 << 20));
            endcase
            set_window(w);
            phase_no = phase;
            quiet = (phase == PHASES - 1);
            repeat (ITEMS_PER_PHASE) random_item();
        end
        drain();

        $display("Summary: %0d result words compared over %0d veto window settings,",
                 compared, PHASES + 1);
        $display("Summary: with %0d vetoes, %0d same-time skips and %0d live readouts.",
                 vetoes, skips, live_reads);
        if (fail_count == 0) begin
            $display("pixel_implant_veto_table verification clean");
        end else begin
            $display("pixel_implant_veto_table verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/pivt_pkg.sv
rtl/pivt_ctrl.sv
rtl/pivt_dp.sv
rtl/pixel_implant_veto_table.sv
test/veto_table_monitor.sv
test/tb_pixel_implant_veto_table.sv
